[hw/rtl/lfcc_pkg.sv]
`default_nettype none

package lfcc_pkg;

    // Reflected IEEE CRC-32 polynomial, initial value and the last byte index of each framing field.
    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT      = 32'hFFFFFFFF;
    localparam logic [2:0]  HEADER_LAST   = 3'd7;
    localparam logic [1:0]  TRAILER_LAST  = 2'd3;

    typedef enum logic [2:0] {
        STATUS_VERIFIED     = 3'd0,
        STATUS_MISMATCH     = 3'd1,
        STATUS_PAYLOAD_LOST = 3'd2,
        STATUS_HEADER_LOST  = 3'd3,
        STATUS_TRAILER_LOST = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       link_lost;
    } in_item_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
        logic [63:0] bytes_received;
    } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/lfcc_crc8.sv]
`default_nettype none

// One byte of the reflected CRC-32 update, unrolled over the eight bit steps.
module lfcc_crc8
    import lfcc_pkg::*;
(
    input  wire logic [31:0] crc,
    input  wire logic [7:0]  data_byte,
    output logic      [31:0] crc_next
);

    always_comb
    begin
        logic [31:0] c;
        c = crc ^ {24'd0, data_byte};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        crc_next = c;
    end

endmodule

`default_nettype wire

[hw/rtl/lfcc_frame_fsm.sv]
`default_nettype none

// Frame sequencer: header length, payload CRC, trailer compare and link loss handling.
module lfcc_frame_fsm
    import lfcc_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      accept,
    input  wire in_item_t  item,
    output logic           res_valid,
    output out_item_t      res_item
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_PAYLOAD = 3'b010,
        PH_TRAILER = 3'b100
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [2:0]             count_reg, count_next;
    logic [LENGTH_BITS-1:0] length_reg, length_next;
    logic [LENGTH_BITS-1:0] paid_reg, paid_next;
    logic [31:0]            crc_reg, crc_next;
    logic [31:0]            trailer_reg, trailer_next;

    logic [31:0]            crc_upd;
    logic [63:0]            len_shift;
    logic [31:0]            trl_shift;
    logic [LENGTH_BITS-1:0] length_or;
    logic [LENGTH_BITS-1:0] paid_inc;
    logic [31:0]            trailer_or;
    logic                   finish;

    lfcc_crc8 u_crc8 (
        .crc       (crc_reg),
        .data_byte (item.data_byte),
        .crc_next  (crc_upd)
    );

    assign len_shift  = {56'd0, item.data_byte} << {count_reg, 3'b000};
    assign trl_shift  = {24'd0, item.data_byte} << {count_reg[1:0], 3'b000};
    assign length_or  = length_reg | len_shift[LENGTH_BITS-1:0];
    assign paid_inc   = paid_reg + 1'b1;
    assign trailer_or = trailer_reg | trl_shift;

    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        length_next  = length_reg;
        paid_next    = paid_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        finish       = 1'b0;

        res_item.status         = STATUS_HEADER_LOST;
        res_item.computed_crc   = ~crc_reg;
        res_item.received_crc   = trailer_reg;
        res_item.bytes_received = 64'(paid_reg);

        if (accept)
        begin
            if (item.link_lost)
            begin
                finish = 1'b1;
                case (phase_reg)
                    PH_PAYLOAD: res_item.status = STATUS_PAYLOAD_LOST;
                    PH_TRAILER: res_item.status = STATUS_TRAILER_LOST;
                    default:    res_item.status = STATUS_HEADER_LOST;
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_PAYLOAD:
                    begin
                        crc_next  = crc_upd;
                        paid_next = paid_inc;
                        if (paid_inc == length_reg)
                        begin
                            phase_next = PH_TRAILER;
                            count_next = 3'd0;
                        end
                    end
                    PH_TRAILER:
                    begin
                        trailer_next = trailer_or;
                        if (count_reg[1:0] == TRAILER_LAST)
                        begin
                            finish                = 1'b1;
                            res_item.received_crc = trailer_or;
                            res_item.status       = (trailer_or == ~crc_reg) ?
                                                    STATUS_VERIFIED : STATUS_MISMATCH;
                        end
                        else
                        begin
                            count_next = count_reg + 3'd1;
                        end
                    end
                    default:
                    begin
                        length_next = length_or;
                        if (count_reg == HEADER_LAST)
                        begin
                            count_next = 3'd0;
                            phase_next = (length_or == '0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                        else
                        begin
                            count_next = count_reg + 3'd1;
                        end
                    end
                endcase
            end
        end

        // Every status rearms the sequencer for the next frame.
        if (finish)
        begin
            phase_next   = PH_HEADER;
            count_next   = 3'd0;
            length_next  = '0;
            paid_next    = '0;
            crc_next     = CRC_INIT;
            trailer_next = 32'd0;
        end

        res_valid = finish;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            count_reg   <= 3'd0;
            length_reg  <= '0;
            paid_reg    <= '0;
            crc_reg     <= CRC_INIT;
            trailer_reg <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            length_reg  <= length_next;
            paid_reg    <= paid_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/lfcc_out_skid.sv]
`default_nettype none

// Result register with one skid entry; the input stall is the skid occupancy.
module lfcc_out_skid
    import lfcc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      res_valid,
    input  wire out_item_t res_item,
    output logic           full,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_item
);

    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t skid_item_reg, skid_item_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;

        if (!out_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_valid;
                out_item_next  = res_item;
            end
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = res_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    assign full         = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

`default_nettype wire

[hw/rtl/length_framed_crc32_checker.sv]
// Length-framed CRC-32 checker.
// The byte channel (byte_valid, byte_stall, byte_item) carries one stream byte per item,
// or a link loss mark. A frame is an 8-byte little-endian payload length, the payload,
// and a 4-byte little-endian CRC-32 trailer. The reflected IEEE CRC-32 runs over the payload.
// The result channel (result_valid, result_stall, result_item) gives one item per frame:
// verified or mismatch after the last trailer byte, or a loss status when a link loss item
// ends the frame early. Items that do not end a frame give no result.
// Throughput is one byte item per clock while byte_stall is low; the CRC byte update,
// length capture and payload count compare are combinational between the state registers.
// The result is registered: when the output register can take it, it appears on result_valid
// after the edge that accepted the byte that ended the frame.
// When the receiver stalls, the held result stays in the output register and one more
// result can be parked in a skid entry; byte_stall rises only while that entry is full,
// and it is driven from a register.
// Reset clears both result entries and puts the sequencer in the header phase
// with the CRC preset to all ones.
`default_nettype none

module length_framed_crc32_checker
    import lfcc_pkg::*;
#(
    parameter int LENGTH_BITS = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      byte_valid,
    output logic           byte_stall,
    input  wire in_item_t  byte_item,
    output logic           result_valid,
    input  wire logic      result_stall,
    output out_item_t      result_item
);

    logic      accept;
    logic      res_valid;
    out_item_t res_item;
    logic      skid_full;

    // An item is taken whenever the skid entry is free, even while a result waits.
    assign accept     = byte_valid && !skid_full;
    assign byte_stall = skid_full;

    lfcc_frame_fsm #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (byte_item),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    lfcc_out_skid u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res_item     (res_item),
        .full         (skid_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

endmodule

`default_nettype wire

[hw/rtl/lfcc_checker.sv]
`default_nettype none

module lfcc_checker
    import lfcc_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      byte_stall,
    input wire logic      result_valid,
    input wire logic      result_stall,
    input wire out_item_t result_item
);

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_item))
        else $error("stalled result changed");

    // With both entries full and the output stalled, nothing can drain.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall && result_valid && result_stall |=> byte_stall)
        else $error("input stall dropped while results were blocked");

    a_verified: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == STATUS_VERIFIED
        |-> result_item.computed_crc == result_item.received_crc)
        else $error("verified status with differing CRC values");

    a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == STATUS_MISMATCH
        |-> result_item.computed_crc != result_item.received_crc)
        else $error("mismatch status with equal CRC values");

    a_header_lost: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.status == STATUS_HEADER_LOST
        |-> result_item.bytes_received == 64'd0 && result_item.computed_crc == 32'd0
            && result_item.received_crc == 32'd0)
        else $error("header loss result carries frame data");

endmodule

bind length_framed_crc32_checker lfcc_checker u_lfcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
);

`default_nettype wire
